### hdl/mi64_pkg.sv
// Shared types and constants for the 64-bit modular inverse block.
package mi64_pkg;

	localparam int unsigned W = 64;

	typedef logic [W-1:0] word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a and p, set up the first division p / a
		logic div_start; // start division num / den
		logic update;    // apply quotient: cofactor and remainder shift
		logic finish;    // form the final result
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic trivial;   // a >= p or a < 3: result known at load
		logic den_le1;
	} dp_sts_t;

endpackage

### hdl/mi64_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, with a shift-add quotient multiply.
module mi64_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mi64_pkg::word_t dividend,
	input  mi64_pkg::word_t divisor,
	input  mi64_pkg::word_t mcand,
	output logic            done,
	output mi64_pkg::word_t remainder,
	output mi64_pkg::word_t product
);
	import mi64_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	word_t        quo_q;
	word_t        dvs_q;
	word_t        mcd_q;
	word_t        prod_q;
	logic [W:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic         busy_q;
	logic [W:0]   trial;
	logic [W:0]   shifted;
	logic         qbit;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign qbit    = ~trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// product accumulates quotient * mcand (mod 2^64), quotient bits MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			dvs_q  <= divisor;
			mcd_q  <= mcand;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? trial : shifted;
			quo_q  <= {quo_q[W-2:0], qbit};
			prod_q <= {prod_q[W-2:0], 1'b0} + (qbit ? mcd_q : '0);
		end
	end

	assign remainder = rem_q[W-1:0];
	assign product   = prod_q;

endmodule

### hdl/mi64_dp.sv
// Datapath: operand, cofactor and parity registers around the shared divider.
module mi64_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mi64_pkg::dp_cmd_t cmd,
	output mi64_pkg::dp_sts_t sts,
	input  mi64_pkg::word_t   value_a,
	input  mi64_pkg::word_t   modulus_p,
	output mi64_pkg::word_t   inverse,
	output logic              invalid
);
	import mi64_pkg::*;

	word_t p_q, num_q, den_q, c0_q, c1_q, res_q;
	logic  odd_q, bad_q, triv_q;
	word_t dr, dprod;
	logic  ddone;

	mi64_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.mcand    (c1_q),
		.done     (ddone),
		.remainder(dr),
		.product  (dprod)
	);

	// c1 = 1, c0 = 0, odd = 1 makes the first step p / a yield c1 = p / a, c0 = 1, odd = 0
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q   <= modulus_p;
			num_q <= modulus_p;
			den_q <= value_a;
			c0_q  <= '0;
			c1_q  <= W'(1);
			odd_q <= 1'b1;
			if (value_a >= modulus_p) begin
				res_q <= '0; bad_q <= 1'b1; triv_q <= 1'b1;
			end else if (value_a < W'(2)) begin
				res_q <= value_a; bad_q <= 1'b0; triv_q <= 1'b1;
			end else if (value_a == W'(2)) begin
				res_q  <= (modulus_p >> 1) + W'(modulus_p[0]);
				bad_q  <= 1'b0; triv_q <= 1'b1;
			end else begin
				res_q <= '0; bad_q <= 1'b0; triv_q <= 1'b0;
			end
		end else if (cmd.update) begin
			c1_q  <= dprod + c0_q;
			c0_q  <= c1_q;
			odd_q <= ~odd_q;
			num_q <= den_q;
			den_q <= dr;
		end else if (cmd.finish) begin
			if (den_q == '0) begin
				res_q <= '0; bad_q <= 1'b1;
			end else begin
				res_q <= odd_q ? c1_q : p_q - c1_q;
				bad_q <= 1'b0;
			end
		end
	end

	assign sts.div_done = ddone;
	assign sts.trivial  = triv_q;
	assign sts.den_le1  = (den_q[W-1:1] == '0);
	assign inverse      = res_q;
	assign invalid      = bad_q;

endmodule

### hdl/mi64_ctrl.sv
// Controller: sequences the Euclid steps and the result handshake.
module mi64_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	output logic              idle,
	input  logic              out_taken,
	output logic              out_busy,
	output mi64_pkg::dp_cmd_t cmd,
	input  mi64_pkg::dp_sts_t sts
);
	import mi64_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_fire;
		cmd.div_start = (state_q == S_CHECK) & ~sts.trivial & ~sts.den_le1;
		cmd.update    = (state_q == S_DIV) & sts.div_done;
		cmd.finish    = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (in_fire) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.trivial) state_q <= S_OUT;
					else if (sts.den_le1) state_q <= S_FIN;
					else state_q <= S_DIV;
				end
				S_DIV:   if (sts.div_done) state_q <= S_CHECK;
				S_FIN:   state_q <= S_OUT;
				S_OUT:   if (out_taken) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle     = (state_q == S_IDLE);
	assign out_busy = (state_q == S_OUT);

	property p_out_from_work;
		@(posedge clk) disable iff (!arst_n)
		$rose(out_busy) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_FIN);
	endproperty
	a_out_from_work: assert property (p_out_from_work) else $error("bad entry to output");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> idle) else $error("load while busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV) else $error("divider done out of step");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy && !out_taken |=> out_busy) else $error("result dropped");

endmodule

### hdl/modular_inverse_64.sv
// Top level of the 64-bit extended Euclidean modular inverse.
// One transaction in, one out; the block holds one item at a time and s_axis_tready is
// high only while it is idle. Each Euclid step runs the check state, the iterations of
// the shared restoring divider (which also forms quotient * cofactor by shift-add) and
// an update that applies the step; an item needs up to about 93 divisions for 64-bit
// operands. Operands with a < 3 or a >= p go from the check state straight to the
// output. Any m_axis_tready stall holds the result, and after each result is taken
// the block returns to idle before it accepts the next item.
module modular_inverse_64 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // value_a[63:0], modulus_p[127:64]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,  // inverse[63:0]
	output logic          m_axis_tuser   // invalid
);
	import mi64_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle, out_busy, in_fire;

	assign s_axis_tready = idle;
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	mi64_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.idle     (idle),
		.out_taken(m_axis_tready),
		.out_busy (out_busy),
		.cmd      (cmd),
		.sts      (sts)
	);

	mi64_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.value_a  (s_axis_tdata[63:0]),
		.modulus_p(s_axis_tdata[127:64]),
		.inverse  (m_axis_tdata),
		.invalid  (m_axis_tuser)
	);

	assign m_axis_tvalid = out_busy;

endmodule
